// ----- rtl/spjq_pkg.sv -----
// Shared types and codes for the stable priority job queue.
// No dependencies; used by spjq_cell, stable_priority_job_queue_unit and tb_top.
package spjq_pkg;

    localparam logic [1:0] REQ_SUBMIT   = 2'd0;
    localparam logic [1:0] REQ_REASSIGN = 2'd1;
    localparam logic [1:0] REQ_CANCEL   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int PAGES_W = 16;
    localparam int TOTAL_W = 32;
    localparam int QCNT_W  = 5;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [PAGES_W-1:0] pages;
    } job_t;

    typedef struct packed {
        cell_op_t        op;
        job_t            job;
        logic [ID_W-1:0] key;
    } cell_cmd_t;

endpackage

// ----- rtl/spjq_cell.sv -----
// One queue slot of the sorted job chain: holds a job and shifts toward
// its neighbors on insert or remove. Depends on spjq_pkg.
module spjq_cell
    import spjq_pkg::*;
(
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      valid,
    input  logic      left_keep,
    input  logic      left_hit,
    input  job_t      left_entry,
    input  job_t      right_entry,
    output logic      keep,
    output logic      hit,
    output logic      first,
    output job_t      entry
);

    job_t entry_reg;
    job_t entry_next;
    logic match;

    assign entry = entry_reg;
    assign keep  = valid && (entry_reg.prio <= cmd.job.prio);
    assign match = valid && (entry_reg.id == cmd.key);
    assign hit   = left_hit | match;
    assign first = match & ~left_hit;

    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CELL_INSERT: begin
                if (!keep) begin
                    entry_next = left_keep ? cmd.job : left_entry;
                end
            end
            CELL_REMOVE: begin
                if (hit) begin
                    entry_next = right_entry;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/stable_priority_job_queue_unit.sv -----
// Top level of the stable priority job queue: request sequencer, counters,
// result register and a chain of spjq_cell slots. Depends on spjq_pkg.
//
// Usage:
//   s_axis carries one request per transaction (submit, reassign, cancel)
//   together with the printer state. m_axis returns one result per request:
//   status, assigned id, cancel flag, the queue head and the counts.
//   Each request runs one chain operation in ST_EXEC, then ST_DONE loads
//   the result register and raises m_tvalid; a reassign that finds its job
//   passes ST_INSERT between them (remove, then insert). The next request
//   is accepted in the cycle after the result is loaded, so a new request
//   is taken only once the last one is through.
//   The result register holds while m_tready is low; a finished request
//   waits in its last step until the register frees, and s_tready stays low.
//   Reset empties the queue, sets the next job id to 1 and clears the
//   submitted count; the slot contents are not cleared and never read
//   before they are written.
module stable_priority_job_queue_unit
    import spjq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // req_type[1:0], job_id[17:2], priority_req[25:18], pages[41:26],
    // printing_valid[42], printing_id[58:43]
    input  logic [63:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[1:0], assigned_id[17:2], cancel_printing[18], head_valid[19],
    // head_id[35:20], head_priority[43:36], queue_count[48:44],
    // submitted_total[80:49]
    output logic [87:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INSERT,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [1:0]         req_reg;
    logic [ID_W-1:0]    jid_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [PAGES_W-1:0] pages_reg;
    logic               pvalid_reg;
    logic [ID_W-1:0]    pid_reg;
    job_t               job_reg;

    logic [CW-1:0]      count_reg;
    logic [ID_W-1:0]    next_id_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [1:0]         status_reg;
    logic [ID_W-1:0]    assigned_reg;
    logic               cancel_reg;

    logic               m_tvalid_reg;
    logic [87:0]        m_tdata_reg;

    cell_cmd_t          cmd;
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_keep;
    logic [QUEUE_DEPTH-1:0] cell_hit;
    logic [QUEUE_DEPTH-1:0] cell_first;
    job_t               cell_entry [QUEUE_DEPTH];
    job_t               removed_job;
    logic               found;
    logic               cancel_match;
    logic [CW+QCNT_W-1:0] count_ext;
    job_t               head;
    logic               head_valid;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            assign cell_valid[gi] = count_reg > CW'(gi);
            if (gi == 0) begin : g_head
                spjq_cell u_cell (
                    .aclk        (aclk),
                    .cmd         (cmd),
                    .valid       (cell_valid[gi]),
                    .left_keep   (1'b1),
                    .left_hit    (1'b0),
                    .left_entry  (cmd.job),
                    .right_entry (cell_entry[(gi + 1) % QUEUE_DEPTH]),
                    .keep        (cell_keep[gi]),
                    .hit         (cell_hit[gi]),
                    .first       (cell_first[gi]),
                    .entry       (cell_entry[gi])
                );
            end else if (gi == QUEUE_DEPTH - 1) begin : g_tail
                spjq_cell u_cell (
                    .aclk        (aclk),
                    .cmd         (cmd),
                    .valid       (cell_valid[gi]),
                    .left_keep   (cell_keep[gi-1]),
                    .left_hit    (cell_hit[gi-1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi]),
                    .keep        (cell_keep[gi]),
                    .hit         (cell_hit[gi]),
                    .first       (cell_first[gi]),
                    .entry       (cell_entry[gi])
                );
            end else begin : g_mid
                spjq_cell u_cell (
                    .aclk        (aclk),
                    .cmd         (cmd),
                    .valid       (cell_valid[gi]),
                    .left_keep   (cell_keep[gi-1]),
                    .left_hit    (cell_hit[gi-1]),
                    .left_entry  (cell_entry[gi-1]),
                    .right_entry (cell_entry[gi+1]),
                    .keep        (cell_keep[gi]),
                    .hit         (cell_hit[gi]),
                    .first       (cell_first[gi]),
                    .entry       (cell_entry[gi])
                );
            end
        end
    endgenerate

    assign found        = cell_hit[QUEUE_DEPTH-1];
    assign cancel_match = pvalid_reg && (pid_reg == jid_reg);

    always_comb begin
        removed_job = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (cell_first[i]) begin
                removed_job = removed_job | cell_entry[i];
            end
        end
    end

    always_comb begin
        cmd.op  = CELL_HOLD;
        cmd.key = jid_reg;
        cmd.job = job_reg;
        unique case (state_reg)
            ST_EXEC: begin
                case (req_reg)
                    REQ_SUBMIT: begin
                        cmd.job = '{id: next_id_reg, prio: prio_reg, pages: pages_reg};
                        if (count_reg != CW'(QUEUE_DEPTH)) begin
                            cmd.op = CELL_INSERT;
                        end
                    end
                    REQ_REASSIGN: cmd.op = CELL_REMOVE;
                    REQ_CANCEL: begin
                        if (!cancel_match) begin
                            cmd.op = CELL_REMOVE;
                        end
                    end
                    default: cmd.op = CELL_HOLD;
                endcase
            end
            ST_INSERT: cmd.op = CELL_INSERT;
            default:   cmd.op = CELL_HOLD;
        endcase
    end

    assign head_valid = count_reg != '0;
    assign head       = head_valid ? cell_entry[0] : '0;
    assign count_ext  = {{QCNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            next_id_reg  <= ID_W'(1);
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg      <= s_tdata[1:0];
                        jid_reg      <= s_tdata[17:2];
                        prio_reg     <= s_tdata[25:18];
                        pages_reg    <= s_tdata[41:26];
                        pvalid_reg   <= s_tdata[42];
                        pid_reg      <= s_tdata[58:43];
                        status_reg   <= STATUS_OK;
                        assigned_reg <= '0;
                        cancel_reg   <= 1'b0;
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    case (req_reg)
                        REQ_SUBMIT: begin
                            state_reg <= ST_DONE;
                            if (count_reg == CW'(QUEUE_DEPTH)) begin
                                status_reg <= STATUS_FULL;
                            end else begin
                                assigned_reg <= next_id_reg;
                                next_id_reg  <= (next_id_reg == '1) ? ID_W'(1)
                                                                    : next_id_reg + 1'b1;
                                count_reg    <= count_reg + 1'b1;
                                if (total_reg != '1) begin
                                    total_reg <= total_reg + 1'b1;
                                end
                            end
                        end
                        REQ_REASSIGN: begin
                            if (found) begin
                                job_reg   <= '{id: removed_job.id, prio: prio_reg,
                                               pages: removed_job.pages};
                                count_reg <= count_reg - 1'b1;
                                state_reg <= ST_INSERT;
                            end else begin
                                status_reg <= STATUS_NOT_FOUND;
                                state_reg  <= ST_DONE;
                            end
                        end
                        REQ_CANCEL: begin
                            state_reg <= ST_DONE;
                            if (cancel_match) begin
                                cancel_reg <= 1'b1;
                            end else if (found) begin
                                count_reg <= count_reg - 1'b1;
                                if (total_reg != '0) begin
                                    total_reg <= total_reg - 1'b1;
                                end
                            end else begin
                                status_reg <= STATUS_NOT_FOUND;
                            end
                        end
                        default: state_reg <= ST_DONE;
                    endcase
                end
                ST_INSERT: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {7'd0, total_reg, count_ext[QCNT_W-1:0],
                                         head.prio, head.id, head_valid, cancel_reg,
                                         assigned_reg, status_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for stable_priority_job_queue_unit: directed and random
// request streams on s_*, every m_* transaction checked against an in-bench job queue model.
// Depends on spjq_pkg and the unit under test; stands alone otherwise.
module tb_top;
    import spjq_pkg::*;

    localparam int         QUEUE_DEPTH = 16;
    localparam logic [1:0] REQ_SPARE   = 2'd3;
    localparam int         MAX_REPORTS = 10;

    typedef struct packed {
        logic [ID_W-1:0]    printing_id;
        logic               printing_valid;
        logic [PAGES_W-1:0] pages;
        logic [PRIO_W-1:0]  priority_req;
        logic [ID_W-1:0]    job_id;
        logic [1:0]         req_type;
    } job_request_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] submitted_total;
        logic [QCNT_W-1:0]  queue_count;
        logic [PRIO_W-1:0]  head_priority;
        logic [ID_W-1:0]    head_id;
        logic               head_valid;
        logic               cancel_printing;
        logic [ID_W-1:0]    assigned_id;
        logic [1:0]         status;
    } queue_report_t;

    typedef struct packed {
        job_t [QUEUE_DEPTH-1:0] slots;
        logic [QCNT_W-1:0]      count;
        logic [ID_W-1:0]        next_id;
        logic [TOTAL_W-1:0]     submitted;
    } job_queue_state_t;

    typedef struct packed {
        logic         hold_until_drained;
        logic         calm;
        job_request_t req;
    } pending_request_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [63:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    pending_request_t pending_requests [$];
    queue_report_t    expected_reports [$];
    job_queue_state_t plan_queue;
    job_queue_state_t model_queue;
    pending_request_t cur_item;
    queue_report_t    predicted;
    queue_report_t    seen;
    queue_report_t    wanted;
    bit               req_taken = 1'b0;
    bit               quiet     = 1'b0;
    int               fault_count = 0;

    stable_priority_job_queue_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #6 aclk = ~aclk;

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    function automatic job_queue_state_t empty_queue();
        job_queue_state_t st;
        st.slots     = '0;
        st.count     = '0;
        st.next_id   = 16'd1;
        st.submitted = '0;
        return st;
    endfunction

    function automatic int find_job(job_queue_state_t st, logic [ID_W-1:0] id);
        int i;
        for (i = 0; i < st.count; i++) begin
            if (st.slots[i].id == id) return i;
        end
        return -1;
    endfunction

    function automatic void drop_slot(inout job_queue_state_t st, input int pos);
        int i;
        for (i = pos; i + 1 < st.count; i++) st.slots[i] = st.slots[i + 1];
        if (st.count > 0) st.count = st.count - 1'b1;
    endfunction

    function automatic void place_job(inout job_queue_state_t st, input job_t j);
        int pos;
        int i;
        pos = 0;
        while (pos < st.count && st.slots[pos].prio <= j.prio) pos++;
        for (i = st.count; i > pos; i--) st.slots[i] = st.slots[i - 1];
        st.slots[pos] = j;
        st.count = st.count + 1'b1;
    endfunction

    function automatic void serve_request(inout job_queue_state_t st,
                                          input job_request_t rq,
                                          output queue_report_t rep);
        job_t j;
        int   pos;
        rep = '0;
        rep.status = STATUS_OK;
        case (rq.req_type)
            REQ_SUBMIT: begin
                if (st.count >= QUEUE_DEPTH) begin
                    rep.status = STATUS_FULL;
                end else begin
                    j.id    = st.next_id;
                    j.prio  = rq.priority_req;
                    j.pages = rq.pages;
                    rep.assigned_id = st.next_id;
                    st.next_id = (st.next_id == 16'hFFFF) ? 16'd1 : st.next_id + 16'd1;
                    place_job(st, j);
                    if (st.submitted != '1) st.submitted = st.submitted + 1'b1;
                end
            end
            REQ_REASSIGN: begin
                pos = find_job(st, rq.job_id);
                if (pos < 0) begin
                    rep.status = STATUS_NOT_FOUND;
                end else begin
                    j = st.slots[pos];
                    drop_slot(st, pos);
                    j.prio = rq.priority_req;
                    place_job(st, j);
                end
            end
            REQ_CANCEL: begin
                if (rq.printing_valid && rq.printing_id == rq.job_id) begin
                    rep.cancel_printing = 1'b1;
                end else begin
                    pos = find_job(st, rq.job_id);
                    if (pos < 0) begin
                        rep.status = STATUS_NOT_FOUND;
                    end else begin
                        drop_slot(st, pos);
                        if (st.submitted != '0) st.submitted = st.submitted - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (st.count > 0) begin
            rep.head_valid    = 1'b1;
            rep.head_id       = st.slots[0].id;
            rep.head_priority = st.slots[0].prio;
        end
        rep.queue_count     = st.count;
        rep.submitted_total = st.submitted;
    endfunction

    function automatic job_request_t make_request(logic [1:0] t, logic [ID_W-1:0] jid,
                                                  logic [PRIO_W-1:0] pr, logic [PAGES_W-1:0] pg,
                                                  logic pv, logic [ID_W-1:0] pid);
        job_request_t rq;
        rq.req_type       = t;
        rq.job_id         = jid;
        rq.priority_req   = pr;
        rq.pages          = pg;
        rq.printing_valid = pv;
        rq.printing_id    = pid;
        return rq;
    endfunction

    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2, 3:    return 8'($urandom);
            default: return 8'($urandom_range(6));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_target();
        if (plan_queue.count > 0 && $urandom_range(99) < 85)
            return plan_queue.slots[$urandom_range(plan_queue.count - 1)].id;
        return 16'($urandom);
    endfunction

    function automatic string fmt_report(queue_report_t r);
        return $sformatf("st=%0d aid=%0d cxl=%0d hv=%0d hid=%0d hpr=%0d cnt=%0d tot=%0d",
                         r.status, r.assigned_id, r.cancel_printing, r.head_valid,
                         r.head_id, r.head_priority, r.queue_count, r.submitted_total);
    endfunction

    task automatic enqueue_request(job_request_t rq, bit hold, bit calm);
        pending_request_t p;
        queue_report_t    scratch;
        p.req                = rq;
        p.hold_until_drained = hold;
        p.calm               = calm;
        pending_requests.push_back(p);
        serve_request(plan_queue, rq, scratch);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || req_taken) begin
                req_taken = 1'b0;
                if (pending_requests.size() > 0 &&
                    !(pending_requests[0].hold_until_drained && expected_reports.size() != 0) &&
                    (pending_requests[0].calm || $urandom_range(99) >= 22)) begin
                    cur_item = pending_requests.pop_front();
                    quiet    = cur_item.calm;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, cur_item.req};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= quiet || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            serve_request(model_queue, cur_item.req, predicted);
            expected_reports.push_back(predicted);
            req_taken = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata[80:0];
            if (expected_reports.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result: %s", fmt_report(seen));
            end else begin
                wanted = expected_reports.pop_front();
                if (seen.status !== wanted.status ||
                    seen.assigned_id !== wanted.assigned_id ||
                    seen.cancel_printing !== wanted.cancel_printing ||
                    seen.head_valid !== wanted.head_valid ||
                    seen.head_id !== wanted.head_id ||
                    seen.head_priority !== wanted.head_priority ||
                    seen.queue_count !== wanted.queue_count ||
                    seen.submitted_total !== wanted.submitted_total) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("mismatch: expected %s", fmt_report(wanted));
                        $display("          actual   %s", fmt_report(seen));
                    end
                end
            end
        end
    end

    initial begin
        logic [PRIO_W-1:0] dir_prio [16];
        logic [ID_W-1:0]   jid;
        logic [ID_W-1:0]   pid;
        logic [1:0]        t;
        logic              pv;
        job_request_t      rq;
        int                k;
        int                n;
        int                roll;
        int                kind;
        int                sub_weight;

        plan_queue  = empty_queue();
        model_queue = empty_queue();
        dir_prio = '{8'd255, 8'd0, 8'd0, 8'd128, 8'd5, 8'd5, 8'd5, 8'd1,
                     8'd254, 8'd0, 8'd7, 8'd7, 8'd3, 8'd255, 8'd128, 8'd2};

        enqueue_request(make_request(REQ_CANCEL, 16'h0000, 8'h00, 16'h0000, 1'b0, 16'h0000), 0, 0);
        enqueue_request(make_request(REQ_REASSIGN, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b0, 16'h0000),
                        0, 0);
        enqueue_request(make_request(REQ_SPARE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, 16'hFFFF), 0, 0);
        for (k = 0; k < 16; k++) begin
            rq = make_request(REQ_SUBMIT, 16'($urandom), dir_prio[k],
                              (k == 0) ? 16'hFFFF : (k == 1) ? 16'h0000 : 16'($urandom),
                              1'($urandom), 16'($urandom));
            enqueue_request(rq, 0, 0);
        end
        enqueue_request(make_request(REQ_SUBMIT, 16'h1234, 8'd0, 16'hFFFF, 1'b1, 16'h0001), 0, 0);
        enqueue_request(make_request(REQ_REASSIGN, 16'd2, 8'd0, 16'h0000, 1'b1, 16'd2), 0, 0);
        enqueue_request(make_request(REQ_REASSIGN, 16'd1, 8'd255, 16'h0000, 1'b0, 16'd0), 0, 0);
        enqueue_request(make_request(REQ_CANCEL, 16'd5, 8'd0, 16'h0000, 1'b1, 16'd5), 0, 0);
        enqueue_request(make_request(REQ_CANCEL, 16'd5, 8'd0, 16'h0000, 1'b1, 16'd7), 0, 0);
        enqueue_request(make_request(REQ_CANCEL, 16'd5, 8'd0, 16'h0000, 1'b0, 16'd5), 0, 0);
        enqueue_request(make_request(REQ_REASSIGN, 16'hFFFF, 8'd9, 16'h0000, 1'b1, 16'hFFFF), 0, 0);

        sub_weight = 45;
        for (n = 0; n < 700; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(2))
                    0:       sub_weight = 15;
                    1:       sub_weight = 45;
                    default: sub_weight = 75;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < sub_weight) begin
                rq = make_request(REQ_SUBMIT, 16'($urandom), pick_priority(), 16'($urandom),
                                  1'($urandom), 16'($urandom));
            end else begin
                kind = $urandom_range(9);
                jid  = pick_target();
                pv   = 1'($urandom);
                pid  = ($urandom_range(3) == 0) ? jid : pick_target();
                if (kind < 4) begin
                    t = REQ_REASSIGN;
                end else if (kind < 8) begin
                    t = REQ_CANCEL;
                end else if (kind == 8) begin
                    t = REQ_SPARE;
                end else begin
                    t   = REQ_CANCEL;
                    jid = 16'($urandom);
                end
                rq = make_request(t, jid, pick_priority(), 16'($urandom), pv, pid);
            end
            enqueue_request(rq, n == 500, n >= 300 && n < 400);
        end

        while (pending_requests.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
        fault_count += expected_reports.size();
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
